FILE: hdl/delimited_packet_deframer_queue_macros.svh
// Assertion macros shared by the deframer queue.
`ifndef DELIMITED_PACKET_DEFRAMER_QUEUE_MACROS_SVH
`define DELIMITED_PACKET_DEFRAMER_QUEUE_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define DPDQ_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deframer queue check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define DPDQ_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deframer queue check failed");

`endif

FILE: hdl/dpdq_pkg.sv
`default_nettype none

package dpdq_pkg;

   // Packet and queue dimensions.
   localparam int MAX_LEN = 64;
   localparam int SLOTS   = 8;

   // Field widths.
   localparam int LEN_W  = 7;
   localparam int BYTE_W = 8;

   // One spare physical slot keeps the assembly area apart from queued packets.
   localparam int PHYS_SLOTS = SLOTS + 1;
   localparam int SLOT_W     = $clog2(PHYS_SLOTS);
   localparam int OFS_W      = $clog2(MAX_LEN);
   localparam int RAM_DEPTH  = PHYS_SLOTS * (2 ** OFS_W);
   localparam int RAM_AW     = $clog2(RAM_DEPTH);
   localparam int USED_W     = $clog2(SLOTS + 1);

   localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(PHYS_SLOTS - 1);
   localparam logic [USED_W-1:0] USED_FULL  = USED_W'(SLOTS);
   localparam logic [LEN_W-1:0]  LEN_LIMIT  = LEN_W'(MAX_LEN);

   // Framing characters.
   localparam logic [BYTE_W-1:0] START_CHAR = 8'h40;
   localparam logic [BYTE_W-1:0] CR_CHAR    = 8'h0D;
   localparam logic [BYTE_W-1:0] LF_CHAR    = 8'h0A;

   // Request codes.
   typedef enum logic [1:0] {
      REQ_BYTE  = 2'd0,
      REQ_POP   = 2'd1,
      REQ_CLEAR = 2'd2
   } req_code_type;

   // Pop sequencer states.
   typedef enum logic {
      POP_IDLE,
      POP_RUN
   } pop_state_type;

   // Completed packet handed from the assembler to the queue.
   typedef struct packed {
      logic             valid;
      logic [LEN_W-1:0] len;
   } commit_type;

   // Next physical slot around the ring.
   function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] r;
      if (s == SLOT_LAST) begin
         r = '0;
      end else begin
         r = s + 1'b1;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/dpdq_ram.sv
`default_nettype none

module dpdq_ram #(
   parameter int DEPTH = 576,
   parameter int WIDTH = 8,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hdl/dpdq_rx.sv
`default_nettype none

module dpdq_rx (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          byte_take,
   input  wire logic                          clear_take,
   input  wire logic [dpdq_pkg::BYTE_W-1:0]   rx_byte,
   input  wire logic [dpdq_pkg::SLOT_W-1:0]   wr_slot,
   output logic                               wr_en,
   output logic      [dpdq_pkg::RAM_AW-1:0]   wr_addr,
   output logic      [dpdq_pkg::BYTE_W-1:0]   wr_data,
   output dpdq_pkg::commit_type               commit
);

   import dpdq_pkg::*;

   logic              rcv_ff,  rcv_in;
   logic [LEN_W-1:0]  idx_ff,  idx_in;
   logic [BYTE_W-1:0] prev_ff, prev_in;
   logic [LEN_W-1:0]  idx_next;
   logic [OFS_W-1:0]  ofs;
   logic              term;

   assign idx_next = idx_ff + 1'b1;
   assign term     = (idx_ff != '0) && (prev_ff == CR_CHAR) && (rx_byte == LF_CHAR);

   // Assembly: each stored byte goes straight into the spare slot of the packet memory.
   always_comb begin
      rcv_in      = rcv_ff;
      idx_in      = idx_ff;
      prev_in     = prev_ff;
      wr_en       = 1'b0;
      ofs         = idx_ff[OFS_W-1:0];
      commit      = '0;
      if (clear_take) begin
         idx_in = '0;
      end else if (byte_take) begin
         if (rx_byte == START_CHAR) begin
            rcv_in  = 1'b1;
            ofs     = '0;
            wr_en   = 1'b1;
            idx_in  = LEN_W'(1);
            prev_in = rx_byte;
         end else if (rcv_ff) begin
            wr_en   = 1'b1;
            prev_in = rx_byte;
            if (term) begin
               // CR LF closes the packet; the queue decides whether it has room.
               rcv_in       = 1'b0;
               idx_in       = '0;
               commit.valid = 1'b1;
               commit.len   = idx_next;
            end else if (idx_next >= LEN_LIMIT) begin
               rcv_in = 1'b0;
               idx_in = '0;
            end else begin
               idx_in = idx_next;
            end
         end
      end
   end

   assign wr_addr = {wr_slot, ofs};
   assign wr_data = rx_byte;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         rcv_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         rcv_ff <= rcv_in;
         idx_ff <= idx_in;
      end
   end

   // Last stored byte, for the terminator check.
   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
   end

endmodule

`default_nettype wire

FILE: hdl/dpdq_tx.sv
`default_nettype none

module dpdq_tx (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dpdq_pkg::commit_type          commit,
   input  wire logic                          pop_take,
   output logic                               busy,
   output logic      [dpdq_pkg::SLOT_W-1:0]   wr_slot,
   output logic                               rd_en,
   output logic      [dpdq_pkg::RAM_AW-1:0]   rd_addr,
   input  wire logic [dpdq_pkg::BYTE_W-1:0]   rd_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_pkt_valid,
   output logic      [dpdq_pkg::BYTE_W-1:0]   rsp_pkt_byte,
   output logic      [dpdq_pkg::LEN_W-1:0]    rsp_pkt_len,
   output logic                               rsp_last_byte
);

   import dpdq_pkg::*;

   pop_state_type     state_ff, state_in;
   logic [SLOT_W-1:0] wr_slot_ff, wr_slot_in;
   logic [SLOT_W-1:0] rd_slot_ff, rd_slot_in;
   logic [USED_W-1:0] used_ff, used_in;
   logic [OFS_W-1:0]  cnt_ff, cnt_in;
   logic [LEN_W-1:0]  plen_ff, plen_in;
   logic              rvalid_ff, rvalid_in;
   logic              pv_ff, pv_in;
   logic [LEN_W-1:0]  olen_ff, olen_in;
   logic              last_ff, last_in;
   logic [LEN_W-1:0]  slot_len_ff [PHYS_SLOTS];
   logic              commit_ok;
   logic              out_free;
   logic              is_last;

   assign commit_ok = commit.valid && (used_ff < USED_FULL);
   assign out_free  = !rvalid_ff || !rsp_stall;
   assign is_last   = ((LEN_W'(cnt_ff) + 1'b1) == plen_ff);

   // Queue pointers and the pop sequencer.
   always_comb begin
      state_in   = state_ff;
      wr_slot_in = wr_slot_ff;
      rd_slot_in = rd_slot_ff;
      used_in    = used_ff;
      cnt_in     = cnt_ff;
      plen_in    = plen_ff;
      rvalid_in  = rvalid_ff;
      pv_in      = pv_ff;
      olen_in    = olen_ff;
      last_in    = last_ff;
      rd_en      = 1'b0;
      if (rvalid_ff && !rsp_stall) begin
         rvalid_in = 1'b0;
      end
      if (commit_ok) begin
         wr_slot_in = slot_inc(wr_slot_ff);
         used_in    = used_ff + 1'b1;
      end
      unique case (state_ff)
         POP_IDLE: begin
            if (pop_take) begin
               state_in = POP_RUN;
               cnt_in   = '0;
               plen_in  = (used_ff == '0) ? '0 : slot_len_ff[rd_slot_ff];
            end
         end
         POP_RUN: begin
            if (out_free) begin
               rvalid_in = 1'b1;
               if (plen_ff == '0) begin
                  // Empty queue: one result that carries no byte.
                  pv_in    = 1'b0;
                  olen_in  = '0;
                  last_in  = 1'b1;
                  state_in = POP_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  pv_in   = 1'b1;
                  olen_in = plen_ff;
                  last_in = is_last;
                  cnt_in  = cnt_ff + 1'b1;
                  if (is_last) begin
                     rd_slot_in = slot_inc(rd_slot_ff);
                     used_in    = used_ff - 1'b1;
                     state_in   = POP_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = POP_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= POP_IDLE;
         wr_slot_ff <= '0;
         rd_slot_ff <= '0;
         used_ff    <= '0;
         rvalid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wr_slot_ff <= wr_slot_in;
         rd_slot_ff <= rd_slot_in;
         used_ff    <= used_in;
         rvalid_ff  <= rvalid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      plen_ff <= plen_in;
      pv_ff   <= pv_in;
      olen_ff <= olen_in;
      last_ff <= last_in;
   end

   // Packet lengths, one per physical slot.
   always_ff @(posedge clock) begin
      if (commit_ok) begin
         slot_len_ff[wr_slot_ff] <= commit.len;
      end
   end

   assign busy          = (state_ff == POP_RUN);
   assign wr_slot       = wr_slot_ff;
   assign rd_addr       = {rd_slot_ff, cnt_ff};
   assign rsp_valid     = rvalid_ff;
   assign rsp_pkt_valid = pv_ff;
   assign rsp_pkt_byte  = pv_ff ? rd_data : '0;
   assign rsp_pkt_len   = olen_ff;
   assign rsp_last_byte = last_ff;

endmodule

`default_nettype wire

FILE: hdl/delimited_packet_deframer_queue.sv
// Delimited packet deframer with a queue of complete packets.
// Request channel (req_valid, req_stall, req_type, req_rx_byte): a received byte,
// a pop of the oldest packet, or a clear of the assembly index. A byte '@' opens
// a packet; a packet closed by CR LF is queued if one of the 8 slots is free,
// else dropped. A packet that reaches 64 bytes without CR LF is discarded.
// Byte and clear requests give no result.
// A pop holds req_stall until the last byte of the packet has been read. The slot
// length is looked up in the cycle of the pop transfer, and then one byte per cycle
// is read out of the packet memory, whose registered read sets the pipeline depth,
// while no result waits under rsp_stall. A pop on an empty queue holds req_stall
// and gives one result with rsp_pkt_valid low and rsp_last_byte high.
// Response channel (rsp_valid, rsp_stall, rsp_*): an output register holds each
// result; while rsp_stall is high the result holds and the sequencer waits.
// The next request is taken while the final result still waits for its transfer.
// Reset clears the queue and the assembler at once; no memory clearing pass.
`default_nettype none

module delimited_packet_deframer_queue (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_type,
   input  wire logic [dpdq_pkg::BYTE_W-1:0]   req_rx_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_pkt_valid,
   output logic      [dpdq_pkg::BYTE_W-1:0]   rsp_pkt_byte,
   output logic      [dpdq_pkg::LEN_W-1:0]    rsp_pkt_len,
   output logic                               rsp_last_byte
);

   import dpdq_pkg::*;

`include "delimited_packet_deframer_queue_macros.svh"

   logic                req_take;
   logic                byte_take;
   logic                pop_take;
   logic                clear_take;
   logic                busy;
   logic [SLOT_W-1:0]   wr_slot;
   logic                wr_en;
   logic [RAM_AW-1:0]   wr_addr;
   logic [BYTE_W-1:0]   wr_data;
   logic                rd_en;
   logic [RAM_AW-1:0]   rd_addr;
   logic [BYTE_W-1:0]   rd_data;
   commit_type          commit;

   // Request decode on each transfer.
   assign req_stall  = busy;
   assign req_take   = req_valid && !busy;
   assign byte_take  = req_take && (req_type == REQ_BYTE);
   assign pop_take   = req_take && (req_type == REQ_POP);
   assign clear_take = req_take && (req_type == REQ_CLEAR);

   dpdq_rx u_rx (
      .clock      (clock),
      .reset      (reset),
      .byte_take  (byte_take),
      .clear_take (clear_take),
      .rx_byte    (req_rx_byte),
      .wr_slot    (wr_slot),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .commit     (commit)
   );

   dpdq_ram #(
      .DEPTH (RAM_DEPTH),
      .WIDTH (BYTE_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   dpdq_tx u_tx (
      .clock         (clock),
      .reset         (reset),
      .commit        (commit),
      .pop_take      (pop_take),
      .busy          (busy),
      .wr_slot       (wr_slot),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pkt_valid (rsp_pkt_valid),
      .rsp_pkt_byte  (rsp_pkt_byte),
      .rsp_pkt_len   (rsp_pkt_len),
      .rsp_last_byte (rsp_last_byte)
   );

   // A pop transfer always starts the sequencer, which then holds off requests.
   `DPDQ_ASSERT_NEXT(a_pop_busy, pop_take, req_stall)
   // A result that carries a byte reports a nonzero packet length.
   `DPDQ_ASSERT_IMP(a_len_nonzero, rsp_valid && rsp_pkt_valid, rsp_pkt_len != '0)
   // The empty-queue result is always the last of its pop.
   `DPDQ_ASSERT_IMP(a_empty_last, rsp_valid && !rsp_pkt_valid, rsp_last_byte && (rsp_pkt_byte == '0))
   // The memory is never read and written in the same cycle.
   `DPDQ_ASSERT_IMP(a_port_excl, rd_en, !wr_en)

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`default_nettype none

module tb_top;
   import dpdq_pkg::*;

   // Request code that the block must ignore.
   localparam logic [1:0] REQ_SPARE = 2'd3;

   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_ITEMS = 30;

   // One popped packet byte, or the empty-queue marker.
   typedef struct {
      logic             present;
      logic [BYTE_W-1:0] data;
      logic [LEN_W-1:0]  len;
      logic             last;
   } pkt_result_type;

   // Scoreboard: tracks the framer and the packet ring, and checks every popped byte.
   class packet_scoreboard;
      logic [BYTE_W-1:0] frame_buf [MAX_LEN];
      int unsigned       frame_idx;
      bit                in_frame;
      logic [BYTE_W-1:0] slot_bytes [SLOTS][MAX_LEN];
      int unsigned       slot_size [SLOTS];
      int unsigned       wr_slot;
      int unsigned       rd_slot;
      int unsigned       queued;
      pkt_result_type    expected_bytes [$];
      int unsigned       error_count;

      function new();
         frame_idx   = 0;
         in_frame    = 0;
         wr_slot     = 0;
         rd_slot     = 0;
         queued      = 0;
         error_count = 0;
      endfunction

      function int unsigned pending();
         return expected_bytes.size();
      endfunction

      // Advance the framer and the ring for one accepted request transfer.
      function void note_request(logic [1:0] kind, logic [BYTE_W-1:0] data);
         pkt_result_type r;
         int unsigned n;
         case (kind)
            REQ_BYTE: begin
               if (data == START_CHAR) begin
                  // A start character always opens a fresh packet.
                  in_frame     = 1;
                  frame_buf[0] = data;
                  frame_idx    = 1;
               end else if (in_frame) begin
                  frame_buf[frame_idx] = data;
                  frame_idx++;
                  // The terminator is checked before the length limit.
                  if (frame_idx >= 2 && frame_buf[frame_idx-2] == CR_CHAR &&
                      frame_buf[frame_idx-1] == LF_CHAR) begin
                     in_frame = 0;
                     if (queued < SLOTS) begin
                        for (int i = 0; i < int'(frame_idx); i++) begin
                           slot_bytes[wr_slot][i] = frame_buf[i];
                        end
                        slot_size[wr_slot] = frame_idx;
                        wr_slot = (wr_slot + 1) % SLOTS;
                        queued++;
                     end
                     frame_idx = 0;
                  end
                  if (frame_idx >= MAX_LEN) begin
                     in_frame  = 0;
                     frame_idx = 0;
                  end
               end
            end
            REQ_POP: begin
               if (queued == 0) begin
                  r.present = 1'b0;
                  r.data    = '0;
                  r.len     = '0;
                  r.last    = 1'b1;
                  expected_bytes.push_back(r);
               end else begin
                  n = slot_size[rd_slot];
                  for (int i = 0; i < int'(n); i++) begin
                     r.present = 1'b1;
                     r.data    = slot_bytes[rd_slot][i];
                     r.len     = LEN_W'(n);
                     r.last    = (i + 1 == int'(n));
                     expected_bytes.push_back(r);
                  end
                  rd_slot = (rd_slot + 1) % SLOTS;
                  queued--;
               end
            end
            REQ_CLEAR: begin
               // Only the index goes back; an open packet stays open.
               frame_idx = 0;
            end
            default: begin
            end
         endcase
      endfunction

      // Compare one result transfer with the oldest expected byte.
      function void check_result(logic present, logic [BYTE_W-1:0] data,
                                 logic [LEN_W-1:0] len, logic last);
         pkt_result_type e;
         if (expected_bytes.size() == 0) begin
            $error("unexpected result: pkt_valid %0d pkt_byte %0h", present, data);
            error_count++;
            return;
         end
         e = expected_bytes.pop_front();
         if (present !== e.present) begin
            $error("pkt_valid: expected %0d, got %0d", e.present, present);
            error_count++;
         end
         if (data !== e.data) begin
            $error("pkt_byte: expected %0h, got %0h", e.data, data);
            error_count++;
         end
         if (len !== e.len) begin
            $error("pkt_len: expected %0d, got %0d", e.len, len);
            error_count++;
         end
         if (last !== e.last) begin
            $error("last_byte: expected %0d, got %0d", e.last, last);
            error_count++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_type;
   logic [BYTE_W-1:0] req_rx_byte;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_pkt_valid;
   logic [BYTE_W-1:0] rsp_pkt_byte;
   logic [LEN_W-1:0]  rsp_pkt_len;
   logic              rsp_last_byte;

   packet_scoreboard  queue_board = new();
   int unsigned       sent_count = 0;
   bit                calm = 0;
   int                cycle_count = 0;
   int                stall_left = 0;
   int                free_left = 0;

   delimited_packet_deframer_queue i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pkt_valid (rsp_pkt_valid),
      .rsp_pkt_byte  (rsp_pkt_byte),
      .rsp_pkt_len   (rsp_pkt_len),
      .rsp_last_byte (rsp_last_byte)
   );

   always #1 clock = ~clock;

   // Run limit; a run that gets here has hung.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Receiver stalls come in bursts, separated by free stretches of varying length.
   always @(posedge clock) begin
      if (calm) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (free_left != 0) begin
         rsp_stall <= 1'b0;
         free_left--;
      end else begin
         rsp_stall <= 1'b0;
         stall_left = $urandom_range(1, 16);
         free_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90) :
                                                  $urandom_range(1, 8);
      end
   end

   // Every result transfer goes to the scoreboard.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         queue_board.check_result(rsp_pkt_valid, rsp_pkt_byte, rsp_pkt_len, rsp_last_byte);
      end
   end

   // Payload byte that neither restarts nor terminates a packet.
   function automatic logic [BYTE_W-1:0] payload_byte();
      logic [BYTE_W-1:0] b;
      b = BYTE_W'($urandom_range(0, 255));
      while (b == START_CHAR || b == CR_CHAR) begin
         b = BYTE_W'($urandom_range(0, 255));
      end
      return b;
   endfunction

   // Present one request, with an occasional idle burst first, and wait for its transfer.
   task automatic send_request(input logic [1:0] kind, input logic [BYTE_W-1:0] data);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_type    <= kind;
      req_rx_byte <= data;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      queue_board.note_request(kind, data);
      sent_count++;
   endtask

   // Start character and payload, no terminator.
   task automatic send_open_packet(input int payload_n);
      send_request(REQ_BYTE, START_CHAR);
      repeat (payload_n) send_request(REQ_BYTE, payload_byte());
   endtask

   task automatic send_packet(input int payload_n);
      send_open_packet(payload_n);
      send_request(REQ_BYTE, CR_CHAR);
      send_request(REQ_BYTE, LF_CHAR);
   endtask

   // Hold the sender off until every expected byte has been transferred.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (queue_board.pending() != 0) @(posedge clock);
   endtask

   // Main sequence.
   initial begin
      int unsigned loop_start;
      int unsigned pick;
      bit          paused;

      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_type    <= REQ_BYTE;
      req_rx_byte <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty pop, ignored traffic, shortest packets, restart and clear.
      send_request(REQ_POP, 8'h00);
      send_request(REQ_BYTE, 8'h41);
      send_request(REQ_SPARE, 8'hFF);
      send_packet(0);
      send_request(REQ_BYTE, START_CHAR);
      send_request(REQ_BYTE, 8'h00);
      send_request(REQ_BYTE, 8'hFF);
      send_request(REQ_BYTE, CR_CHAR);
      send_request(REQ_BYTE, LF_CHAR);
      send_request(REQ_BYTE, START_CHAR);
      send_request(REQ_BYTE, 8'h31);
      send_request(REQ_BYTE, START_CHAR);
      send_request(REQ_BYTE, 8'h32);
      send_request(REQ_BYTE, CR_CHAR);
      send_request(REQ_BYTE, LF_CHAR);
      send_request(REQ_BYTE, START_CHAR);
      send_request(REQ_BYTE, 8'h33);
      send_request(REQ_CLEAR, 8'hA5);
      send_request(REQ_BYTE, CR_CHAR);
      send_request(REQ_BYTE, LF_CHAR);
      repeat (5) send_request(REQ_POP, 8'h5A);
      wait_for_drain();

      // Fill the ring past capacity, then the longest packet and an overlong one.
      repeat (9) send_packet($urandom_range(0, 1));
      repeat (2) send_request(REQ_POP, BYTE_W'($urandom_range(0, 255)));
      send_packet(MAX_LEN - 3);
      send_open_packet(MAX_LEN - 1);
      send_request(REQ_BYTE, CR_CHAR);
      send_request(REQ_BYTE, LF_CHAR);

      // Random mix, mostly well-formed packets with random content.
      loop_start = sent_count;
      paused = 0;
      while (sent_count < loop_start + RANDOM_ITEMS) begin
         if (!paused && sent_count >= loop_start + RANDOM_ITEMS / 2) begin
            wait_for_drain();
            paused = 1;
         end
         if (sent_count >= loop_start + RANDOM_ITEMS - 10) begin
            calm = 1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            send_packet(($urandom_range(0, 3) == 0) ? $urandom_range(6, 20) :
                                                      $urandom_range(0, 5));
         end else if (pick < 70) begin
            send_request(REQ_POP, BYTE_W'($urandom_range(0, 255)));
         end else if (pick < 76) begin
            send_request(REQ_CLEAR, BYTE_W'($urandom_range(0, 255)));
         end else if (pick < 82) begin
            send_request(REQ_BYTE, BYTE_W'($urandom_range(0, 255)));
         end else if (pick < 85) begin
            send_request(REQ_SPARE, BYTE_W'($urandom_range(0, 255)));
         end else if (pick < 92) begin
            send_open_packet($urandom_range(0, 6));
         end else begin
            send_open_packet($urandom_range(0, 4));
            send_request(REQ_CLEAR, BYTE_W'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 4)) send_request(REQ_BYTE, payload_byte());
            send_request(REQ_BYTE, CR_CHAR);
            send_request(REQ_BYTE, LF_CHAR);
         end
      end

      // Empty the ring, then one more pop that finds it empty.
      calm = 1;
      while (queue_board.queued != 0) send_request(REQ_POP, BYTE_W'($urandom_range(0, 255)));
      send_request(REQ_POP, BYTE_W'($urandom_range(0, 255)));
      wait_for_drain();
      repeat (20) @(posedge clock);

      if (queue_board.error_count == 0 && queue_board.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
